// File: hdl/fps_pkg.sv
package fps_pkg;

  // field widths
  localparam int TIME_W  = 32;
  localparam int CMD_W   = 2;
  localparam int ANGLE_W = 16;
  localparam int ALT_W   = 24;
  localparam int PHASE_W = 3;
  localparam int SD_W    = 2;

  // configuration register widths
  localparam int BURN_W    = 16;
  localparam int ABORT_W   = 15;
  localparam int SPACING_W = 16;
  localparam int CHECK_W   = 16;
  localparam int MARGIN_W  = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 17;

  // previous average minus descent margin, signed
  localparam int DIFF_W = 25;

  localparam int SAMPLE_COUNT_DEF = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BURN_TIME = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ABORT_ANG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN    = 3'd4;

  // configuration reset values
  localparam logic [BURN_W-1:0]    BURN_RST    = 16'd3000;
  localparam logic [ABORT_W-1:0]   ABORT_RST   = 15'd3000;
  localparam logic [SPACING_W-1:0] SPACING_RST = 16'd50;
  localparam logic [CHECK_W-1:0]   CHECK_RST   = 16'd1000;
  localparam logic [MARGIN_W-1:0]  MARGIN_RST  = 17'd100;

  // radio commands
  localparam logic [CMD_W-1:0] CMD_NONE      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CALIBRATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LAUNCH    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RESET     = 2'd3;

  // sd dump status codes
  localparam logic [SD_W-1:0] SD_NONE    = 2'd0;
  localparam logic [SD_W-1:0] SD_DUMPING = 2'd1;
  localparam logic [SD_W-1:0] SD_OK      = 2'd2;
  localparam logic [SD_W-1:0] SD_FAIL    = 2'd3;

  // external phase codes
  localparam logic [PHASE_W-1:0] PH_PAD       = 3'd0;
  localparam logic [PHASE_W-1:0] PH_CALIBRATE = 3'd1;
  localparam logic [PHASE_W-1:0] PH_COUNTDOWN = 3'd2;
  localparam logic [PHASE_W-1:0] PH_ASCENT    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_UNPOWERED = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DESCENT   = 3'd5;
  localparam logic [PHASE_W-1:0] PH_ABORT     = 3'd6;
  localparam logic [PHASE_W-1:0] PH_GROUND    = 3'd7;

  // flight phase state, one-hot
  typedef enum logic [7:0] {
    ST_PAD       = 8'b0000_0001,
    ST_CALIBRATE = 8'b0000_0010,
    ST_COUNTDOWN = 8'b0000_0100,
    ST_ASCENT    = 8'b0000_1000,
    ST_UNPOWERED = 8'b0001_0000,
    ST_DESCENT   = 8'b0010_0000,
    ST_ABORT     = 8'b0100_0000,
    ST_GROUND    = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [BURN_W-1:0]    burn_time_ms;
    logic [ABORT_W-1:0]   abort_angle;
    logic [SPACING_W-1:0] sample_spacing_ms;
    logic [CHECK_W-1:0]   check_interval_ms;
    logic [MARGIN_W-1:0]  descent_margin;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]         now_ms;
    logic [CMD_W-1:0]          command;
    logic                      launch_detected;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] yaw_angle;
    logic signed [ALT_W-1:0]   altitude;
    logic                      dump_ok;
  } item_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [SD_W-1:0]    sd_status;
    logic               launch_arm;
    logic               separation_fire;
    logic               control_active;
    logic               sensor_reset_pulse;
    logic               log_sample;
  } result_t;

  // one-hot state to external phase code
  function automatic logic [PHASE_W-1:0] phase_code(phase_t st);
    logic [PHASE_W-1:0] code;
    case (st)
      ST_PAD:       code = PH_PAD;
      ST_CALIBRATE: code = PH_CALIBRATE;
      ST_COUNTDOWN: code = PH_COUNTDOWN;
      ST_ASCENT:    code = PH_ASCENT;
      ST_UNPOWERED: code = PH_UNPOWERED;
      ST_DESCENT:   code = PH_DESCENT;
      ST_ABORT:     code = PH_ABORT;
      ST_GROUND:    code = PH_GROUND;
      default:      code = PH_PAD;
    endcase
    return code;
  endfunction

endpackage

// File: hdl/fps_cfg_regs.sv
module fps_cfg_regs
  import fps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  // register file always takes a transfer
  assign cfg_ready = 1'b1;

  // register write, masked to each register width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.burn_time_ms      <= BURN_RST;
      cfg_r.abort_angle       <= ABORT_RST;
      cfg_r.sample_spacing_ms <= SPACING_RST;
      cfg_r.check_interval_ms <= CHECK_RST;
      cfg_r.descent_margin    <= MARGIN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BURN_TIME: cfg_r.burn_time_ms      <= cfg_data[BURN_W-1:0];
        CFG_ABORT_ANG: cfg_r.abort_angle       <= cfg_data[ABORT_W-1:0];
        CFG_SPACING:   cfg_r.sample_spacing_ms <= cfg_data[SPACING_W-1:0];
        CFG_CHECK:     cfg_r.check_interval_ms <= cfg_data[CHECK_W-1:0];
        CFG_MARGIN:    cfg_r.descent_margin    <= cfg_data[MARGIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hdl/fps_core.sv
module fps_core
  import fps_pkg::*;
#(
  parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  // derived widths for the averaging path
  localparam int LOG_N  = $clog2(SAMPLE_COUNT);
  localparam int CNT_W  = $clog2(SAMPLE_COUNT + 1);
  localparam int SUM_W  = ALT_W + LOG_N;
  localparam int CMP_W  = DIFF_W + CNT_W + 1;
  // offset sum is unsigned and below 2^SUM_W
  localparam int UW     = SUM_W;
  localparam int RW     = UW + 1;
  localparam int SHIFT  = UW + LOG_N;
  localparam int PROD_W = UW + RW;
  localparam logic [63:0] RECIP_64 =
    ((64'd1 << SHIFT) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT);
  localparam logic [RW-1:0] RECIP  = RECIP_64[RW-1:0];
  localparam logic [UW:0]   OFFSET = (UW + 1)'(SAMPLE_COUNT) << (ALT_W - 1);

  // state registers
  phase_t                    phase_r, phase_nxt;
  logic [SD_W-1:0]           sd_r, sd_nxt;
  logic [TIME_W-1:0]         launch_time_r, launch_time_nxt;
  logic [TIME_W-1:0]         mark_r, mark_nxt;
  logic                      sampling_r, sampling_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic signed [ALT_W-1:0]   prev_avg_r;
  logic                      arm_r, arm_nxt;
  logic                      sep_r, sep_nxt;
  logic                      ctrl_r, ctrl_nxt;

  // averaging pipeline
  logic                      pend_r;
  logic [UW-1:0]             pend_sum_r;
  logic                      pend_set;
  logic [UW-1:0]             pend_sum_nxt;
  logic [PROD_W-1:0]         prod;
  logic [ALT_W-1:0]          quot;
  logic signed [ALT_W-1:0]   avg;

  // datapath
  logic [ANGLE_W:0]          abs_pitch, abs_yaw;
  logic [TIME_W-1:0]         since_mark, since_launch;
  logic [CNT_W-1:0]          cnt_inc;
  logic signed [SUM_W-1:0]   full_sum;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [CMP_W-1:0]   thresh;
  logic                      below;
  logic                      pulse, logs;

  // attitude magnitudes
  assign abs_pitch = item.pitch_angle[ANGLE_W-1] ?
                     ((ANGLE_W + 1)'(0) - (ANGLE_W + 1)'(item.pitch_angle)) :
                     (ANGLE_W + 1)'(item.pitch_angle);
  assign abs_yaw   = item.yaw_angle[ANGLE_W-1] ?
                     ((ANGLE_W + 1)'(0) - (ANGLE_W + 1)'(item.yaw_angle)) :
                     (ANGLE_W + 1)'(item.yaw_angle);

  // wrapping elapsed times
  assign since_mark   = item.now_ms - mark_r;
  assign since_launch = item.now_ms - launch_time_r;

  // sample sum and apogee threshold: floor(sum/N) < prev - margin iff sum < (prev - margin)*N
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign full_sum = sum_r + SUM_W'(item.altitude);
  assign diff     = DIFF_W'(prev_avg_r) - $signed(DIFF_W'(cfg.descent_margin));
  assign thresh   = $signed(CMP_W'(diff)) * $signed(CMP_W'(SAMPLE_COUNT));
  assign below    = $signed(CMP_W'(full_sum)) < thresh;
  assign pend_sum_nxt = UW'((UW + 1)'(full_sum) + OFFSET);

  // phase sequencing
  always_comb begin
    phase_nxt       = phase_r;
    sd_nxt          = sd_r;
    launch_time_nxt = launch_time_r;
    mark_nxt        = mark_r;
    sampling_nxt    = sampling_r;
    cnt_nxt         = cnt_r;
    sum_nxt         = sum_r;
    arm_nxt         = arm_r;
    sep_nxt         = sep_r;
    ctrl_nxt        = ctrl_r;
    pulse           = 1'b0;
    logs            = 1'b0;
    pend_set        = 1'b0;
    case (phase_r)
      ST_PAD: begin
        if (item.command == CMD_CALIBRATE) begin
          pulse     = 1'b1;
          phase_nxt = ST_CALIBRATE;
        end
      end
      ST_CALIBRATE: begin
        if (item.command == CMD_LAUNCH) begin
          phase_nxt = ST_COUNTDOWN;
        end
      end
      ST_COUNTDOWN: begin
        arm_nxt = 1'b1;
        if (item.launch_detected) begin
          launch_time_nxt = item.now_ms;
          ctrl_nxt        = 1'b1;
          phase_nxt       = ST_ASCENT;
        end
      end
      ST_ASCENT: begin
        arm_nxt = 1'b0;
        logs    = 1'b1;
        if (abs_pitch >= (ANGLE_W + 1)'(cfg.abort_angle) ||
            abs_yaw >= (ANGLE_W + 1)'(cfg.abort_angle)) begin
          phase_nxt = ST_ABORT;
        end else if (since_launch >= TIME_W'(cfg.burn_time_ms)) begin
          mark_nxt  = item.now_ms;
          phase_nxt = ST_UNPOWERED;
        end
      end
      ST_UNPOWERED: begin
        logs = 1'b1;
        if (!sampling_r) begin
          // idle gap before a burst, no sample on the starting step
          if (since_mark > TIME_W'(cfg.check_interval_ms)) begin
            sampling_nxt = 1'b1;
          end
        end else if (since_mark >= TIME_W'(cfg.sample_spacing_ms)) begin
          mark_nxt = item.now_ms;
          if (cnt_inc < CNT_W'(SAMPLE_COUNT)) begin
            cnt_nxt = cnt_inc;
            sum_nxt = full_sum;
          end else begin
            sampling_nxt = 1'b0;
            cnt_nxt      = '0;
            sum_nxt      = '0;
            if (below) begin
              ctrl_nxt  = 1'b0;
              phase_nxt = ST_DESCENT;
            end else begin
              pend_set = 1'b1;
            end
          end
        end
      end
      ST_DESCENT, ST_ABORT: begin
        sep_nxt   = 1'b1;
        sd_nxt    = item.dump_ok ? SD_OK : SD_FAIL;
        phase_nxt = ST_GROUND;
      end
      ST_GROUND: begin
      end
      default: begin
      end
    endcase
    if (item.command == CMD_RESET) begin
      phase_nxt = ST_PAD;
    end
  end

  // state update on each processed step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= ST_PAD;
      sd_r          <= SD_NONE;
      launch_time_r <= '0;
      mark_r        <= '0;
      sampling_r    <= 1'b0;
      cnt_r         <= '0;
      sum_r         <= '0;
      arm_r         <= 1'b0;
      sep_r         <= 1'b0;
      ctrl_r        <= 1'b0;
    end else if (step_en) begin
      phase_r       <= phase_nxt;
      sd_r          <= sd_nxt;
      launch_time_r <= launch_time_nxt;
      mark_r        <= mark_nxt;
      sampling_r    <= sampling_nxt;
      cnt_r         <= cnt_nxt;
      sum_r         <= sum_nxt;
      arm_r         <= arm_nxt;
      sep_r         <= sep_nxt;
      ctrl_r        <= ctrl_nxt;
    end
  end

  // burst average by reciprocal multiply of the offset sum, registered in the cycle after the burst
  assign prod = PROD_W'(pend_sum_r) * PROD_W'(RECIP);
  assign quot = prod[SHIFT +: ALT_W];
  assign avg  = $signed({~quot[ALT_W-1], quot[ALT_W-2:0]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= step_en && pend_set;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && pend_set) begin
      pend_sum_r <= pend_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_avg_r <= '0;
    end else if (pend_r) begin
      prev_avg_r <= avg;
    end
  end

  // values after the step
  always_comb begin
    result.phase              = phase_code(phase_nxt);
    result.sd_status          = sd_nxt;
    result.launch_arm         = arm_nxt;
    result.separation_fire    = sep_nxt;
    result.control_active     = ctrl_nxt;
    result.sensor_reset_pulse = pulse;
    result.log_sample         = logs;
  end

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CNT_W'(SAMPLE_COUNT))
    else $error("sample counter beyond burst length");

  a_pend_no_burst: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !(step_en && pend_set))
    else $error("burst completed while average still pending");

  a_sd_no_dumping: assert property (@(posedge clk) disable iff (!rst_n)
    sd_r != SD_DUMPING)
    else $error("transient dumping status stored");

  a_ctrl_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ST_ASCENT || phase_r == ST_UNPOWERED) |-> ctrl_r)
    else $error("control inactive during ascent");

  a_pulse_from_pad: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && pulse) |=> (phase_r == ST_CALIBRATE || phase_r == ST_PAD))
    else $error("calibrate pulse without calibrate entry");

endmodule

// File: hdl/flight_phase_sequencer.sv
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    now_ms command launch_detected pitch yaw alt dump_ok
// out      output     out_valid / out_ready  phase sd_status arm separation control pulse log
// cfg      input      cfg_valid / cfg_ready  cfg_index (3 bit), cfg_data (17 bit)
//
// one item per cycle while out_ready is high; a transfer lands in the input register, the
// step logic updates the phase state and writes the result register when the item advances
// the burst average reaches its register in the cycle after a burst ends
// reset loads the configuration defaults and clears all phase and sampling state
// out_ready low holds the result; one more item waits in the input register,
// then in_ready falls; cfg_ready is always high
module flight_phase_sequencer
  import fps_pkg::*;
#(
  parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [TIME_W-1:0]         in_now_ms,
  input  logic [CMD_W-1:0]          in_command,
  input  logic                      in_launch_detected,
  input  logic signed [ANGLE_W-1:0] in_pitch_angle,
  input  logic signed [ANGLE_W-1:0] in_yaw_angle,
  input  logic signed [ALT_W-1:0]   in_altitude,
  input  logic                      in_dump_ok,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [PHASE_W-1:0]        out_phase,
  output logic [SD_W-1:0]           out_sd_status,
  output logic                      out_launch_arm,
  output logic                      out_separation_fire,
  output logic                      out_control_active,
  output logic                      out_sensor_reset_pulse,
  output logic                      out_log_sample,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DAT_W-1:0]      cfg_data
);

  cfg_t    cfg;
  item_t   item_r;
  logic    in_valid_r;
  result_t step_res;
  result_t result_r;
  logic    out_valid_r;
  logic    advance;

  fps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // held item moves on when the result register is free or draining
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.now_ms          <= in_now_ms;
      item_r.command         <= in_command;
      item_r.launch_detected <= in_launch_detected;
      item_r.pitch_angle     <= in_pitch_angle;
      item_r.yaw_angle       <= in_yaw_angle;
      item_r.altitude        <= in_altitude;
      item_r.dump_ok         <= in_dump_ok;
    end
  end

  fps_core #(
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item_r),
    .cfg     (cfg),
    .result  (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= step_res;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_phase              = result_r.phase;
  assign out_sd_status          = result_r.sd_status;
  assign out_launch_arm         = result_r.launch_arm;
  assign out_separation_fire    = result_r.separation_fire;
  assign out_control_active     = result_r.control_active;
  assign out_sensor_reset_pulse = result_r.sensor_reset_pulse;
  assign out_log_sample         = result_r.log_sample;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import fps_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 6;
  // input register, step register and the late burst average
  localparam int DRAIN_CYCLES = 4;
  localparam int STALL_LIMIT  = 1000;
  localparam int MAX_REPORTS  = 10;
  localparam int ANGLE_MAX    = 18000;
  localparam int ALT_MAX      = 2 ** (ALT_W - 1) - 1;
  localparam int ALT_MIN      = -(2 ** (ALT_W - 1));
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_MARGIN + 3'd1;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [TIME_W-1:0]         in_now_ms = '0;
  logic [CMD_W-1:0]          in_command = CMD_NONE;
  logic                      in_launch_detected = 1'b0;
  logic signed [ANGLE_W-1:0] in_pitch_angle = '0;
  logic signed [ANGLE_W-1:0] in_yaw_angle = '0;
  logic signed [ALT_W-1:0]   in_altitude = '0;
  logic                      in_dump_ok = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [PHASE_W-1:0]        out_phase;
  logic [SD_W-1:0]           out_sd_status;
  logic                      out_launch_arm;
  logic                      out_separation_fire;
  logic                      out_control_active;
  logic                      out_sensor_reset_pulse;
  logic                      out_log_sample;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = CFG_BURN_TIME;
  logic [CFG_DAT_W-1:0]      cfg_data = '0;

  // shadow of the sequencer state
  logic [PHASE_W-1:0]   fl_phase = PH_PAD;
  logic [SD_W-1:0]      fl_sd = SD_NONE;
  logic [TIME_W-1:0]    fl_launch_ms = '0;
  logic [TIME_W-1:0]    fl_mark_ms = '0;
  bit                   fl_burst = 1'b0;
  int                   fl_samples = 0;
  longint               fl_alt_sum = 0;
  longint               fl_prev_avg = 0;
  bit                   fl_arm = 1'b0;
  bit                   fl_sep = 1'b0;
  bit                   fl_ctrl = 1'b0;

  // shadow of the configuration registers
  logic [BURN_W-1:0]    set_burn = BURN_RST;
  logic [ABORT_W-1:0]   set_abort = ABORT_RST;
  logic [SPACING_W-1:0] set_spacing = SPACING_RST;
  logic [CHECK_W-1:0]   set_check = CHECK_RST;
  logic [MARGIN_W-1:0]  set_margin = MARGIN_RST;

  result_t           expected_steps[$];
  int                mismatches = 0;
  int                results_seen = 0;
  int                idle_cycles = 0;
  bit                steady = 1'b0;
  logic [TIME_W-1:0] clock_ms = '0;
  int                height = 0;
  int                climb = 0;

  flight_phase_sequencer u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_now_ms              (in_now_ms),
    .in_command             (in_command),
    .in_launch_detected     (in_launch_detected),
    .in_pitch_angle         (in_pitch_angle),
    .in_yaw_angle           (in_yaw_angle),
    .in_altitude            (in_altitude),
    .in_dump_ok             (in_dump_ok),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_phase              (out_phase),
    .out_sd_status          (out_sd_status),
    .out_launch_arm         (out_launch_arm),
    .out_separation_fire    (out_separation_fire),
    .out_control_active     (out_control_active),
    .out_sensor_reset_pulse (out_sensor_reset_pulse),
    .out_log_sample         (out_log_sample),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // one control-loop step of the flight sequence, updates the shadow state
  function automatic result_t fly_step(input item_t it);
    result_t           r;
    longint            tilt_p;
    longint            tilt_y;
    longint            avg;
    logic [TIME_W-1:0] since;
    bit                apogee;
    r = '0;
    apogee = 1'b0;
    case (fl_phase)
      PH_PAD: begin
        if (it.command == CMD_CALIBRATE) begin
          r.sensor_reset_pulse = 1'b1;
          fl_phase = PH_CALIBRATE;
        end
      end
      PH_CALIBRATE: begin
        if (it.command == CMD_LAUNCH) fl_phase = PH_COUNTDOWN;
      end
      PH_COUNTDOWN: begin
        fl_arm = 1'b1;
        if (it.launch_detected) begin
          fl_launch_ms = it.now_ms;
          fl_ctrl = 1'b1;
          fl_phase = PH_ASCENT;
        end
      end
      PH_ASCENT: begin
        tilt_p = longint'(it.pitch_angle);
        tilt_y = longint'(it.yaw_angle);
        if (tilt_p < 0) tilt_p = -tilt_p;
        if (tilt_y < 0) tilt_y = -tilt_y;
        fl_arm = 1'b0;
        r.log_sample = 1'b1;
        since = it.now_ms - fl_launch_ms;
        if (tilt_p >= longint'(set_abort) || tilt_y >= longint'(set_abort)) begin
          fl_phase = PH_ABORT;
        end else if (since >= set_burn) begin
          fl_mark_ms = it.now_ms;
          fl_phase = PH_UNPOWERED;
        end
      end
      PH_UNPOWERED: begin
        r.log_sample = 1'b1;
        since = it.now_ms - fl_mark_ms;
        // a burst opens without a sample, then samples at the spacing
        if (!fl_burst) begin
          if (since > set_check) fl_burst = 1'b1;
        end else if (since >= set_spacing) begin
          fl_mark_ms = it.now_ms;
          fl_samples++;
          fl_alt_sum += longint'(it.altitude);
          if (fl_samples >= SAMPLE_COUNT_DEF) begin
            // floor division of the burst sum
            avg = fl_alt_sum / SAMPLE_COUNT_DEF;
            if (fl_alt_sum % SAMPLE_COUNT_DEF != 0 && fl_alt_sum < 0) avg--;
            fl_burst = 1'b0;
            fl_samples = 0;
            fl_alt_sum = 0;
            if (fl_prev_avg > avg + longint'(set_margin)) apogee = 1'b1;
            else fl_prev_avg = avg;
          end
        end
        if (apogee) begin
          fl_ctrl = 1'b0;
          fl_phase = PH_DESCENT;
        end
      end
      PH_DESCENT, PH_ABORT: begin
        fl_sep = 1'b1;
        fl_sd = it.dump_ok ? SD_OK : SD_FAIL;
        fl_phase = PH_GROUND;
      end
      default: ;
    endcase
    // reset command wins over any phase, outputs are kept
    if (it.command == CMD_RESET) fl_phase = PH_PAD;
    r.phase = fl_phase;
    r.sd_status = fl_sd;
    r.launch_arm = fl_arm;
    r.separation_fire = fl_sep;
    r.control_active = fl_ctrl;
    return r;
  endfunction

  // one step transfer, valid is left high so back-to-back steps keep it up
  task automatic send_step(input item_t it);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_now_ms <= it.now_ms;
    in_command <= it.command;
    in_launch_detected <= it.launch_detected;
    in_pitch_angle <= it.pitch_angle;
    in_yaw_angle <= it.yaw_angle;
    in_altitude <= it.altitude;
    in_dump_ok <= it.dump_ok;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_steps.push_back(fly_step(it));
  endtask

  task automatic step(input logic [TIME_W-1:0] t, input logic [CMD_W-1:0] cmd,
                      input bit launch, input int pitch, input int yaw, input int alt,
                      input bit dump);
    item_t it;
    it.now_ms = t;
    it.command = cmd;
    it.launch_detected = launch;
    it.pitch_angle = ANGLE_W'(pitch);
    it.yaw_angle = ANGLE_W'(yaw);
    it.altitude = ALT_W'(alt);
    it.dump_ok = dump;
    send_step(it);
  endtask

  // hold the sender until every result is back and the block has settled
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_BURN_TIME: set_burn = data[BURN_W-1:0];
      CFG_ABORT_ANG: set_abort = data[ABORT_W-1:0];
      CFG_SPACING:   set_spacing = data[SPACING_W-1:0];
      CFG_CHECK:     set_check = data[CHECK_W-1:0];
      CFG_MARGIN:    set_margin = data[MARGIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int burn, input int abort, input int spacing,
                           input int check, input int margin);
    wait_drained();
    // junk above the burn, abort, spacing and check register widths must be dropped
    write_reg(CFG_BURN_TIME, CFG_DAT_W'(burn | ($urandom_range(0, 1) << BURN_W)));
    write_reg(CFG_ABORT_ANG, CFG_DAT_W'(abort | ($urandom_range(0, 3) << ABORT_W)));
    write_reg(CFG_SPACING, CFG_DAT_W'(spacing | ($urandom_range(0, 1) << SPACING_W)));
    write_reg(CFG_CHECK, CFG_DAT_W'(check | ($urandom_range(0, 1) << CHECK_W)));
    write_reg(CFG_MARGIN, CFG_DAT_W'(margin));
    // unused index, no effect
    write_reg(CFG_IDX_W'(CFG_SPARE_LO + $urandom_range(0, 2)), CFG_DAT_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic configure_random(input int abort);
    configure($urandom_range(0, 150), abort, $urandom_range(0, 30), $urandom_range(0, 60),
              $urandom_range(0, 2000));
  endtask

  // mostly well-formed flights with random content, some noise on top
  task automatic fly_random(input int count, input int stride,
                            input logic [TIME_W-1:0] start_ms);
    item_t it;
    int    tilt;
    int    alt_val;
    clock_ms = start_ms;
    for (int n = 0; n < count; n++) begin
      if (n % 32 == 0) steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 79) == 0) wait_drained();
      clock_ms += $urandom_range(0, stride);
      if ($urandom_range(0, 63) == 0) clock_ms = $urandom;
      it = '0;
      it.now_ms = clock_ms;
      it.dump_ok = 1'($urandom_range(0, 1));
      // attitude mostly inside the abort cone, sometimes well past it
      tilt = (fl_phase == PH_ASCENT && $urandom_range(0, 9) == 0) ?
             ANGLE_MAX : (set_abort * 3) / 4;
      it.pitch_angle = ANGLE_W'($urandom_range(0, 2 * tilt) - tilt);
      it.yaw_angle = ANGLE_W'($urandom_range(0, 2 * tilt) - tilt);
      // trajectory climbs, slows after burnout and falls
      if (fl_phase == PH_ASCENT || fl_phase == PH_UNPOWERED) begin
        height += climb;
        if (fl_phase == PH_UNPOWERED) climb -= $urandom_range(20, 300);
      end
      alt_val = height + $urandom_range(0, 100) - 50;
      if (alt_val > ALT_MAX) alt_val = ALT_MAX;
      if (alt_val < ALT_MIN) alt_val = ALT_MIN;
      it.altitude = ALT_W'(alt_val);
      case (fl_phase)
        PH_PAD:       it.command = ($urandom_range(0, 2) == 0) ? CMD_NONE : CMD_CALIBRATE;
        PH_CALIBRATE: it.command = ($urandom_range(0, 2) == 0) ? CMD_NONE : CMD_LAUNCH;
        PH_COUNTDOWN: begin
          it.launch_detected = ($urandom_range(0, 2) != 0);
          if (it.launch_detected) begin
            height = $urandom_range(0, 20000) - 5000;
            climb = $urandom_range(300, 3000);
          end
        end
        PH_GROUND:    it.command = ($urandom_range(0, 2) == 0) ? CMD_RESET : CMD_NONE;
        default: ;
      endcase
      // noise: any command or value, broken sequences included
      if ($urandom_range(0, 9) == 0) begin
        it.command = CMD_W'($urandom);
        it.launch_detected = 1'($urandom);
        it.pitch_angle = ANGLE_W'($urandom_range(0, 2 * ANGLE_MAX) - ANGLE_MAX);
        it.yaw_angle = ANGLE_W'($urandom_range(0, 2 * ANGLE_MAX) - ANGLE_MAX);
        it.altitude = ALT_W'($urandom);
      end
      send_step(it);
    end
    steady = 1'b0;
  endtask

  // pad commands, field extremes, reset from calibrate
  task automatic test_pad_commands();
    step(32'h0000_0000, CMD_NONE, 1'b1, ANGLE_MAX, -ANGLE_MAX, ALT_MIN, 1'b1);
    step(32'hFFFF_FFFF, CMD_LAUNCH, 1'b0, -ANGLE_MAX, ANGLE_MAX, ALT_MAX, 1'b0);
    step(32'd1, CMD_RESET, 1'b1, 0, 0, 0, 1'b0);
    step(32'd2, CMD_CALIBRATE, 1'b0, 0, 0, 0, 1'b0);
    step(32'd3, CMD_CALIBRATE, 1'b0, 0, 0, 0, 1'b1);
    step(32'd4, CMD_RESET, 1'b0, 0, 0, 0, 1'b0);
  endtask

  // launch, abort exactly on the angle limit, failed dump, ground
  task automatic test_abort_flight();
    step(32'd10, CMD_CALIBRATE, 1'b0, 0, 0, 0, 1'b0);
    step(32'd11, CMD_LAUNCH, 1'b1, 0, 0, 0, 1'b0);
    step(32'd12, CMD_NONE, 1'b0, 0, 0, 0, 1'b0);
    step(32'd13, CMD_CALIBRATE, 1'b1, 0, 0, 0, 1'b0);
    step(32'd14, CMD_NONE, 1'b0, ABORT_RST - 1, -(ABORT_RST - 1), 0, 1'b0);
    step(32'd15, CMD_NONE, 1'b0, 0, -ABORT_RST, 0, 1'b1);
    step(32'd16, CMD_NONE, 1'b0, 0, 0, 0, 1'b0);
    step(32'd17, CMD_LAUNCH, 1'b0, 0, 0, 0, 1'b1);
    step(32'd18, CMD_RESET, 1'b0, 0, 0, 0, 1'b1);
  endtask

  // zero timers across the clock wrap, burst start needs a strict gap
  task automatic test_short_timers();
    configure(0, ANGLE_MAX, 0, 0, 0);
    step(32'hFFFF_FFF0, CMD_CALIBRATE, 1'b0, 0, 0, 0, 1'b0);
    step(32'hFFFF_FFF8, CMD_LAUNCH, 1'b0, 0, 0, 0, 1'b0);
    step(32'hFFFF_FFFE, CMD_NONE, 1'b1, 0, 0, 0, 1'b0);
    step(32'h0000_0003, CMD_NONE, 1'b0, ANGLE_MAX - 1, -(ANGLE_MAX - 1), 100, 1'b0);
    step(32'h0000_0003, CMD_NONE, 1'b0, 0, 0, 200, 1'b0);
    step(32'h0000_0004, CMD_RESET, 1'b0, 0, 0, 300, 1'b0);
  endtask

  task automatic test_random_flights(input int count);
    configure_random($urandom_range(1500, ANGLE_MAX));
    fly_random(count, 25, $urandom);
  endtask

  task automatic test_clock_wrap();
    configure_random($urandom_range(1500, ANGLE_MAX));
    fly_random(200, 25, 32'hFFFF_F000);
  endtask

  task automatic test_long_timers();
    configure(16'hFFFF, ANGLE_MAX, 16'hFFFF, 16'hFFFF, 100000);
    fly_random(60, 20000, $urandom);
  endtask

  // every ascent step aborts
  task automatic test_zero_abort();
    configure_random(0);
    fly_random(50, 25, $urandom);
  endtask

  // result side: random stalls, compare against the oldest expectation
  initial begin : result_check
    result_t got;
    result_t want;
    int      stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got = {out_phase, out_sd_status, out_launch_arm, out_separation_fire,
             out_control_active, out_sensor_reset_pulse, out_log_sample};
      results_seen++;
      if (expected_steps.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d arrived with nothing expected", results_seen);
      end else begin
        want = expected_steps.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"result %0d: expected phase %0d sd %0d arm/sep/ctrl/pulse/log %b%b%b%b%b,",
                      " got phase %0d sd %0d arm/sep/ctrl/pulse/log %b%b%b%b%b"},
                     results_seen, want.phase, want.sd_status, want.launch_arm,
                     want.separation_fire, want.control_active, want.sensor_reset_pulse,
                     want.log_sample, got.phase, got.sd_status, got.launch_arm,
                     got.separation_fire, got.control_active, got.sensor_reset_pulse,
                     got.log_sample);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("flight_phase_sequencer test failed");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_pad_commands();
    test_abort_flight();
    test_short_timers();
    test_random_flights(200);
    test_clock_wrap();
    test_long_timers();
    test_zero_abort();
    test_random_flights(140);
    wait_drained();
    if (mismatches == 0)
      $display("flight_phase_sequencer test passed");
    else
      $display("flight_phase_sequencer test failed");
    $finish;
  end

endmodule
